@@ hdl/sisr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sisr_pkg
// Shared types, codes and helpers of the seeded id shuffle registry.
// ----------------------------------------------------------------------------
package sisr_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned RESULT_CAP      = 16;

  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

  localparam logic [1:0] ACT_REGISTER = 2'd0;
  localparam logic [1:0] ACT_LOOKUP   = 2'd1;
  localparam logic [1:0] ACT_ROTATE   = 2'd2;

  localparam logic [1:0] KIND_REGISTER = 2'd0;
  localparam logic [1:0] KIND_LOOKUP   = 2'd1;
  localparam logic [1:0] KIND_ROTATION = 2'd2;

  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] ident;
    logic [15:0] season;
    logic [15:0] week;
    logic [7:0]  wanted;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_ident;
    logic [1:0]  reg_status;
    logic        found;
    logic        last;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_RESP,
    S_COPY_RD,
    S_COPY_WR,
    S_STEP,
    S_LCG,
    S_MOD_GO,
    S_MOD_WAIT,
    S_RDA,
    S_RDB,
    S_WRA,
    S_WRB,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

  // xorshift 13/17/5 over the concatenated season and week
  function automatic logic [31:0] mix_seed(input logic [15:0] season,
                                           input logic [15:0] week);
    logic [31:0] s;
    s = {season, week};
    s = s ^ (s << 13);
    s = s ^ (s >> 17);
    s = s ^ (s << 5);
    return s;
  endfunction

endpackage

@@ hdl/sisr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sisr_ram
// Generic single write, single read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sisr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/sisr_mod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sisr_mod
// Bit-serial restoring remainder of a 32-bit word by a small divisor.
// ----------------------------------------------------------------------------
module sisr_mod #(
  parameter int unsigned DW = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] rem
);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [31:0]   dvd_r, dvd_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW:0]   shifted;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    shifted  = {rem_r, dvd_r[31]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // one quotient bit a cycle, remainder stays below the divisor
      if (shifted >= {1'b0, divisor}) begin
        rem_nxt = DW'(shifted - {1'b0, divisor});
      end else begin
        rem_nxt = shifted[DW-1:0];
      end
      dvd_nxt = {dvd_r[30:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

@@ hdl/seeded_id_shuffle_registry.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seeded_id_shuffle_registry
// Table of distinct ids with register, lookup and seeded shuffled rotation.
// ----------------------------------------------------------------------------
// One request is worked at a time; in_stall is high from acceptance until the
// last result beat has been loaded into the output register. Register and
// lookup scan the id memory one entry at a time, a read and then a compare. A
// rotation of n entries copies the table into the work memory, then runs n-1
// shuffle steps, each made of the step, lcg and start states, the wait on the
// bit-serial remainder unit and a swap by two reads and two writes through the
// single read port of the work memory, and then emits the first min(wanted,
// entries, result cap) ids. A rotation of an empty table or with zero wanted
// ids gives no result beat and leaves in_stall low.
// Both memories are undefined after reset and need no clearing pass.
// ----------------------------------------------------------------------------
module seeded_id_shuffle_registry #(
  parameter int unsigned MAX_ENTRIES = sisr_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sisr_pkg::in_beat_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sisr_pkg::out_beat_t out_data
);
  import sisr_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned XW = CW + 8;

  state_t      state_r, state_nxt;
  in_beat_t    op_r;
  logic [CW-1:0] count_r, k_r, i_r, j_r, n_r, emit_r;
  logic [CW-1:0] im1, k_inc, emit_calc;
  logic [XW-1:0] wanted_x, count_x, min_x;
  logic        found_r;
  logic [31:0] prng_r;
  logic [15:0] tmp_r;
  out_beat_t   out_r, out_nxt;
  logic        out_valid_r;
  logic        out_free, out_load, in_acc;

  logic          tab_we, tab_re, wk_we, wk_re;
  logic [AW-1:0] tab_waddr, tab_raddr, wk_waddr, wk_raddr;
  logic [15:0]   tab_wdata, tab_rdata, wk_wdata, wk_rdata;
  logic          mod_start, mod_done;
  logic [CW-1:0] mod_rem;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign im1      = i_r - CW'(1);
  assign k_inc    = k_r + CW'(1);

  // rotation length: min(wanted, entries, result cap)
  always_comb begin
    wanted_x = XW'(in_data.wanted);
    count_x  = XW'(count_r);
    min_x    = (wanted_x < count_x) ? wanted_x : count_x;
    if (min_x > XW'(RESULT_CAP)) begin
      min_x = XW'(RESULT_CAP);
    end
    emit_calc = min_x[CW-1:0];
  end

  sisr_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_tab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .re    (tab_re),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  sisr_ram #(.WIDTH(16), .DEPTH(MAX_ENTRIES)) u_work (
    .clk   (clk),
    .we    (wk_we),
    .waddr (wk_waddr),
    .wdata (wk_wdata),
    .re    (wk_re),
    .raddr (wk_raddr),
    .rdata (wk_rdata)
  );

  sisr_mod #(.DW(CW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (prng_r),
    .divisor  (i_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority if (in_data.action == ACT_REGISTER ||
                       in_data.action == ACT_LOOKUP) begin
            state_nxt = S_SRCH;
          end else if (in_data.action == ACT_ROTATE) begin
            if (count_r != '0 && in_data.wanted != '0) begin
              state_nxt = S_COPY_RD;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SRCH:     state_nxt = (k_r < count_r) ? S_CMP : S_RESP;
      S_CMP:      state_nxt = (tab_rdata == op_r.ident) ? S_RESP : S_SRCH;
      S_RESP:     state_nxt = out_free ? S_IDLE : S_RESP;
      S_COPY_RD:  state_nxt = S_COPY_WR;
      S_COPY_WR:  state_nxt = (k_inc == n_r) ? S_STEP : S_COPY_RD;
      S_STEP:     state_nxt = (i_r > CW'(1)) ? S_LCG : S_EMIT_RD;
      S_LCG:      state_nxt = S_MOD_GO;
      S_MOD_GO:   state_nxt = S_MOD_WAIT;
      S_MOD_WAIT: state_nxt = mod_done ? S_RDA : S_MOD_WAIT;
      S_RDA:      state_nxt = S_RDB;
      S_RDB:      state_nxt = S_WRA;
      S_WRA:      state_nxt = S_WRB;
      S_WRB:      state_nxt = S_STEP;
      S_EMIT_RD:  state_nxt = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (out_free) begin
          state_nxt = (k_inc == emit_r) ? S_IDLE : S_EMIT_RD;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // memory, remainder unit and result controls
  always_comb begin
    tab_we    = 1'b0;
    tab_waddr = count_r[AW-1:0];
    tab_wdata = op_r.ident;
    tab_re    = 1'b0;
    tab_raddr = k_r[AW-1:0];
    wk_we     = 1'b0;
    wk_waddr  = k_r[AW-1:0];
    wk_wdata  = tab_rdata;
    wk_re     = 1'b0;
    wk_raddr  = k_r[AW-1:0];
    mod_start = 1'b0;
    out_load  = 1'b0;
    out_nxt   = out_r;
    unique case (state_r)
      S_SRCH: begin
        tab_re = (k_r < count_r);
      end
      S_RESP: begin
        out_load           = out_free;
        out_nxt.out_ident  = op_r.ident;
        out_nxt.last       = 1'b1;
        if (op_r.action == ACT_REGISTER) begin
          out_nxt.kind  = KIND_REGISTER;
          out_nxt.found = 1'b0;
          priority if (found_r) begin
            out_nxt.reg_status = ST_PRESENT;
          end else if (count_r >= CW'(MAX_ENTRIES)) begin
            out_nxt.reg_status = ST_FULL;
          end else begin
            out_nxt.reg_status = ST_ADDED;
            tab_we             = out_free;
          end
        end else begin
          out_nxt.kind       = KIND_LOOKUP;
          out_nxt.reg_status = ST_ADDED;
          out_nxt.found      = found_r;
        end
      end
      S_COPY_RD: begin
        tab_re = 1'b1;
      end
      S_COPY_WR: begin
        wk_we = 1'b1;
      end
      S_MOD_GO: begin
        mod_start = 1'b1;
      end
      S_RDA: begin
        wk_re    = 1'b1;
        wk_raddr = im1[AW-1:0];
      end
      S_RDB: begin
        wk_re    = 1'b1;
        wk_raddr = j_r[AW-1:0];
      end
      S_WRA: begin
        wk_we    = 1'b1;
        wk_waddr = im1[AW-1:0];
        wk_wdata = wk_rdata;
      end
      S_WRB: begin
        wk_we    = 1'b1;
        wk_waddr = j_r[AW-1:0];
        wk_wdata = tmp_r;
      end
      S_EMIT_RD: begin
        wk_re = 1'b1;
      end
      S_EMIT_OUT: begin
        out_load           = out_free;
        out_nxt.kind       = KIND_ROTATION;
        out_nxt.out_ident  = wk_rdata;
        out_nxt.reg_status = ST_ADDED;
        out_nxt.found      = 1'b0;
        out_nxt.last       = (k_inc == emit_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      prng_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (tab_we) begin
        count_r <= count_r + CW'(1);
      end
      if (state_r == S_COPY_WR && k_inc == n_r) begin
        prng_r <= mix_seed(op_r.season, op_r.week);
      end else if (state_r == S_LCG) begin
        prng_r <= prng_r * LCG_MUL + LCG_ADD;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end

    if (in_acc) begin
      op_r    <= in_data;
      k_r     <= '0;
      found_r <= 1'b0;
      n_r     <= count_r;
      emit_r  <= emit_calc;
    end
    if (state_r == S_CMP) begin
      if (tab_rdata == op_r.ident) begin
        found_r <= 1'b1;
      end else begin
        k_r <= k_inc;
      end
    end
    if (state_r == S_COPY_WR) begin
      k_r <= (k_inc == n_r) ? '0 : k_inc;
      i_r <= n_r;
    end
    if (state_r == S_MOD_WAIT && mod_done) begin
      j_r <= mod_rem;
    end
    if (state_r == S_RDB) begin
      tmp_r <= wk_rdata;
    end
    if (state_r == S_WRB) begin
      i_r <= im1;
    end
    if (state_r == S_EMIT_OUT && out_free) begin
      k_r <= k_inc;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
